// ===== rtl/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants for the free-list slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int POOL_SLOTS = 1024;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    // a head value also needs to hold the empty marker (POOL_SLOTS)
    localparam int HEAD_W     = $clog2(POOL_SLOTS + 1);
    localparam int CFG_W      = 11;

    localparam logic [CFG_W-1:0]  SLOTS_RESET = CFG_W'(1024);
    localparam logic [HEAD_W-1:0] HEAD_EMPTY  = HEAD_W'(POOL_SLOTS);

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        func_t             func;
        logic [SLOT_W-1:0] free_slot;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        status_t           status;
    } out_item_t;

endpackage

// ===== rtl/fsa_ram.sv =====
// ----------------------------------------------------------------------------
// fsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/free_list_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_slot_allocator
// Fixed-slot pool allocator: LIFO free list in a link RAM, with a lazily
// initialised fresh run of slots at the tail of the list.
// ----------------------------------------------------------------------------
//  channel  | ports              | payload
//  ---------+--------------------+-----------------------------------
//  request  | s_valid / s_ready  | s_item  (func, free_slot)
//  result   | m_valid / m_ready  | m_item  (granted_slot, status)
//  config   | cfg_wr_en          | cfg_wr_data (slots_in_use)
//
//  One request per cycle; its result appears in the output register on the
//  following cycle. Throughput is set by the head update loop, which keeps
//  the link of the current head ready (forwarded on free, read from the link
//  RAM ahead on pop). s_ready drops only while a result is held by
//  m_ready low. Synchronous active-low reset; no clearing pass, the link RAM
//  data is only used at entries a free has written.
// ----------------------------------------------------------------------------
module free_list_slot_allocator (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  fsa_pkg::in_item_t       s_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output fsa_pkg::out_item_t      m_item,
    input  logic                    cfg_wr_en,
    input  logic [fsa_pkg::CFG_W-1:0] cfg_wr_data
);
    import fsa_pkg::*;

    logic [CFG_W-1:0]  slots_in_use_reg;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [HEAD_W-1:0] fresh_reg, fresh_next;
    logic [HEAD_W-1:0] head_link_reg, head_link_next;
    logic              link_sel_reg, link_sel_next;
    logic              m_valid_reg;
    out_item_t         m_item_reg, res;

    logic [HEAD_W-1:0] lim, head_link, fresh_inc, ram_rdata;
    logic              s_fire, ram_we, ram_re;

    assign s_fire  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // link of the current head: straight from the RAM after a pop
    assign head_link = link_sel_reg ? ram_rdata : head_link_reg;
    assign lim       = (slots_in_use_reg > CFG_W'(POOL_SLOTS)) ? HEAD_W'(POOL_SLOTS)
                                                               : HEAD_W'(slots_in_use_reg);
    assign fresh_inc = fresh_reg + HEAD_W'(1);

    always_comb begin
        head_next      = head_reg;
        fresh_next     = fresh_reg;
        head_link_next = head_link_reg;
        link_sel_next  = link_sel_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        res            = '{granted_slot: '0, status: ST_OK};
        unique case (s_item.func)
            FUNC_ALLOC: begin
                if (head_reg >= HEAD_EMPTY) begin
                    res.status = ST_EMPTY;
                end else if (head_reg == fresh_reg) begin
                    if (fresh_reg >= lim) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.granted_slot = head_reg[SLOT_W-1:0];
                        fresh_next       = fresh_inc;
                        head_next        = (fresh_inc >= lim) ? HEAD_EMPTY : fresh_inc;
                        link_sel_next    = 1'b0;
                    end
                end else begin
                    res.granted_slot = head_reg[SLOT_W-1:0];
                    head_next        = head_link;
                    ram_re           = s_fire;
                    link_sel_next    = 1'b1;
                end
            end
            FUNC_FREE: begin
                if ({1'b0, s_item.free_slot} >= lim) begin
                    res.status = ST_RANGE;
                end else begin
                    ram_we         = s_fire;
                    head_next      = {1'b0, s_item.free_slot};
                    head_link_next = head_reg;
                    link_sel_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    fsa_ram #(
        .WIDTH(HEAD_W),
        .DEPTH(POOL_SLOTS)
    ) u_link_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(s_item.free_slot),
        .wdata(head_reg),
        .re   (ram_re),
        .raddr(head_link[SLOT_W-1:0]),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= SLOTS_RESET;
            head_reg         <= '0;
            fresh_reg        <= '0;
            link_sel_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slots_in_use_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                head_reg     <= head_next;
                fresh_reg    <= fresh_next;
                link_sel_reg <= link_sel_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            head_link_reg <= head_link_next;
            m_item_reg    <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/fsa_checker.sv =====
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fsa_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input fsa_pkg::out_item_t        m_item
);
    import fsa_pkg::*;

    // nothing pending straight after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // every accepted request yields a result next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

    // single output stage: a held result blocks new requests
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request accepted while result stalled");

    // failed operations grant nothing
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != ST_OK |-> m_item.granted_slot == '0)
        else $error("slot granted on failed operation");

    // held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

endmodule

bind free_list_slot_allocator fsa_checker u_fsa_checker (.*);
